>>> hdl/tam_pkg.sv
// tam_pkg: shared constants for the threshold alert monitor.
// Function codes, register indexes, buzzer modes and field widths.
// No dependencies; used by threshold_alert_monitor_core.
`timescale 1ns / 1ps

package tam_pkg;

  // Field widths
  localparam int unsigned FuncW     = 2;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned ScreenW   = 8;
  localparam int unsigned ZoneCodeW = 4;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned PolicyW   = 2;
  localparam int unsigned CoolW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Zone flags: one bit per zone, at most the mask width
  localparam int unsigned ZoneCount = 8;
  localparam int unsigned ZoneMaskW = 8;

  // Flash phase toggles after this many milliseconds
  localparam logic [TimeW-1:0] PhasePeriodMs = TimeW'(1000);

  // Cooldown in milliseconds: 65535 s * 1000 fits in 26 bits
  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned CoolMsW    = 26;

  // Item function codes
  localparam logic [FuncW-1:0] FuncSlotCheck  = 2'd0;
  localparam logic [FuncW-1:0] FuncCycleBegin = 2'd1;
  localparam logic [FuncW-1:0] FuncCycleEnd   = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBuzzerPolicy = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCooldownSec  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAudioReady   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThreshOff    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFullZone     = 3'd4;

  // Buzzer modes
  localparam logic [PolicyW-1:0] BuzzOff        = 2'd0;
  localparam logic [PolicyW-1:0] BuzzAnyScreen  = 2'd1;
  localparam logic [PolicyW-1:0] BuzzShownOnly  = 2'd2;

  // Register reset values
  localparam logic [PolicyW-1:0]        RstBuzzerPolicy = BuzzAnyScreen;
  localparam logic [CoolMsW-1:0]        RstCooldownMs   = CoolMsW'(60 * MsPerSec);
  localparam logic signed [LimitW-1:0]  RstThreshOff    = 16'sh8000;
  localparam logic [ZoneCodeW-1:0]      RstFullZone     = 4'd15;

endpackage

>>> hdl/threshold_alert_monitor_core.sv
// threshold_alert_monitor_core: alarm monitor over display update cycles.
// Input register, single-pass decision logic, result register.
// Depends on tam_pkg.
//
// Channel   Direction  Handshake                 Payload
// in        receive    in_valid_i / in_stall_o   func_i .. now_ms_i
// out       send       out_valid_o / out_stall_i alarm_hit_o .. remote_alarm_on_o
// cfg       receive    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per clock sustained while out_stall_i is low; an item passes the input register,
// then the result register, with all state updated as it leaves the input register.
// Reset (rst_ni low, asynchronous) clears all state and loads register defaults.
// out_stall_i holds the result register; the input register then fills and
// in_stall_o rises only while both registers are occupied.
// cfg_ready_o is always high; writes to unused indexes are dropped.
`timescale 1ns / 1ps

module threshold_alert_monitor_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input transactions
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [tam_pkg::FuncW-1:0]            func_i,
  input  logic signed [tam_pkg::SampleW-1:0]   sample_value_i,
  input  logic signed [tam_pkg::LimitW-1:0]    low_limit_i,
  input  logic signed [tam_pkg::LimitW-1:0]    high_limit_i,
  input  logic                                 flash_enable_i,
  input  logic                                 buzzer_enable_i,
  input  logic [tam_pkg::ScreenW-1:0]          slot_screen_i,
  input  logic [tam_pkg::ScreenW-1:0]          shown_screen_i,
  input  logic [tam_pkg::ZoneCodeW-1:0]        zone_code_i,
  input  logic [tam_pkg::TimeW-1:0]            now_ms_i,
  // result transactions
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 alarm_hit_o,
  output logic                                 beep_request_o,
  output logic                                 full_flash_start_o,
  output logic                                 full_flash_stop_o,
  output logic [tam_pkg::ZoneMaskW-1:0]        zone_flash_mask_o,
  output logic                                 remote_alarm_on_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tam_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tam_pkg::CfgDataW-1:0]         cfg_data_i
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [tam_pkg::PolicyW-1:0]       buzzer_policy_q;
  logic [tam_pkg::CoolMsW-1:0]       cooldown_ms_q;
  logic                              audio_ready_q;
  logic signed [tam_pkg::LimitW-1:0] thresh_off_q;
  logic [tam_pkg::ZoneCodeW-1:0]     full_zone_q;
  logic                              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Cooldown is kept in milliseconds so the item path has only a compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buzzer_policy_q <= tam_pkg::RstBuzzerPolicy;
      cooldown_ms_q   <= tam_pkg::RstCooldownMs;
      audio_ready_q   <= 1'b0;
      thresh_off_q    <= tam_pkg::RstThreshOff;
      full_zone_q     <= tam_pkg::RstFullZone;
    end else if (cfg_we) begin
      case (cfg_index_i)
        tam_pkg::CfgBuzzerPolicy: buzzer_policy_q <= cfg_data_i[tam_pkg::PolicyW-1:0];
        tam_pkg::CfgCooldownSec: begin
          cooldown_ms_q <= tam_pkg::CoolMsW'(cfg_data_i) *
                           tam_pkg::CoolMsW'(tam_pkg::MsPerSec);
        end
        tam_pkg::CfgAudioReady:   audio_ready_q <= cfg_data_i[0];
        tam_pkg::CfgThreshOff:    thresh_off_q  <= cfg_data_i;
        tam_pkg::CfgFullZone:     full_zone_q   <= cfg_data_i[tam_pkg::ZoneCodeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic                               s1_valid_q;
  logic [tam_pkg::FuncW-1:0]          s1_func_q;
  logic signed [tam_pkg::SampleW-1:0] s1_sample_q;
  logic signed [tam_pkg::LimitW-1:0]  s1_low_q;
  logic signed [tam_pkg::LimitW-1:0]  s1_high_q;
  logic                               s1_flash_en_q;
  logic                               s1_buzz_en_q;
  logic [tam_pkg::ScreenW-1:0]        s1_slot_q;
  logic [tam_pkg::ScreenW-1:0]        s1_shown_q;
  logic [tam_pkg::ZoneCodeW-1:0]      s1_zone_q;
  logic [tam_pkg::TimeW-1:0]          s1_now_q;
  logic                               out_valid_q;
  logic                               s1_adv;
  logic                               in_acc;

  // Item leaves the input register when the result register is free or draining
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc | (s1_valid_q & ~s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q     <= func_i;
      s1_sample_q   <= sample_value_i;
      s1_low_q      <= low_limit_i;
      s1_high_q     <= high_limit_i;
      s1_flash_en_q <= flash_enable_i;
      s1_buzz_en_q  <= buzzer_enable_i;
      s1_slot_q     <= slot_screen_i;
      s1_shown_q    <= shown_screen_i;
      s1_zone_q     <= zone_code_i;
      s1_now_q      <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------
  // Monitor state
  // ---------------------------------------------------------------
  logic [tam_pkg::TimeW-1:0]     last_beep_q, last_beep_d;
  logic                          full_run_q, full_run_d;
  logic                          any_alarm_q, any_alarm_d;
  logic                          cycle_open_q, cycle_open_d;
  logic [tam_pkg::ZoneMaskW-1:0] zone_flags_q, zone_flags_d;
  logic                          phase_q, phase_d;
  logic [tam_pkg::TimeW-1:0]     phase_timer_q, phase_timer_d;
  logic                          remote_q, remote_d;

  // Decision results
  logic hit, beep, fstart, fstop;

  // ---------------------------------------------------------------
  // Single-pass decision logic
  // ---------------------------------------------------------------
  always_comb begin
    logic                               lo_on;
    logic                               hi_on;
    logic signed [tam_pkg::SampleW-1:0] lo_ext;
    logic signed [tam_pkg::SampleW-1:0] hi_ext;
    logic                               alarm;
    logic                               same;
    logic                               want;
    logic                               cool_ok;
    logic [tam_pkg::TimeW-1:0]          beep_age;
    logic [tam_pkg::TimeW-1:0]          phase_age;

    last_beep_d   = last_beep_q;
    full_run_d    = full_run_q;
    any_alarm_d   = any_alarm_q;
    cycle_open_d  = cycle_open_q;
    zone_flags_d  = zone_flags_q;
    phase_d       = phase_q;
    phase_timer_d = phase_timer_q;
    remote_d      = remote_q;
    hit           = 1'b0;
    beep          = 1'b0;
    fstart        = 1'b0;
    fstop         = 1'b0;

    // threshold compares, each disabled by the off code
    lo_on  = (s1_low_q != thresh_off_q);
    hi_on  = (s1_high_q != thresh_off_q);
    lo_ext = tam_pkg::SampleW'(s1_low_q);
    hi_ext = tam_pkg::SampleW'(s1_high_q);
    alarm  = (lo_on & (s1_sample_q <= lo_ext)) | (hi_on & (s1_sample_q >= hi_ext));
    same   = (s1_slot_q == s1_shown_q);

    // buzzer mode and cooldown window (modulo 2^32 age)
    case (buzzer_policy_q)
      tam_pkg::BuzzAnyScreen: want = s1_buzz_en_q;
      tam_pkg::BuzzShownOnly: want = s1_buzz_en_q & same;
      default:                want = 1'b0;
    endcase
    beep_age  = s1_now_q - last_beep_q;
    cool_ok   = (cooldown_ms_q == '0) || (beep_age >= tam_pkg::TimeW'(cooldown_ms_q));
    phase_age = s1_now_q - phase_timer_q;

    case (s1_func_q)
      tam_pkg::FuncSlotCheck: begin
        if (alarm) begin
          hit = 1'b1;
          if (s1_flash_en_q && same) begin
            if (s1_zone_q == full_zone_q) begin
              if (!full_run_q) begin
                full_run_d = 1'b1;
                fstart     = 1'b1;
              end
            end else if (s1_zone_q < tam_pkg::ZoneCodeW'(tam_pkg::ZoneCount)) begin
              zone_flags_d[s1_zone_q[$clog2(tam_pkg::ZoneMaskW)-1:0]] = 1'b1;
            end
            any_alarm_d = 1'b1;
          end else if (!same) begin
            remote_d = 1'b1;
          end
          if (want && cool_ok) begin
            last_beep_d = s1_now_q;
            beep        = audio_ready_q;
          end
        end
      end
      tam_pkg::FuncCycleBegin: begin
        any_alarm_d  = 1'b0;
        cycle_open_d = 1'b1;
        remote_d     = 1'b0;
        zone_flags_d = '0;
        if (phase_age >= tam_pkg::PhasePeriodMs) begin
          phase_timer_d = s1_now_q;
          phase_d       = ~phase_q;
        end
      end
      tam_pkg::FuncCycleEnd: begin
        if (cycle_open_q && !any_alarm_q && full_run_q) begin
          full_run_d = 1'b0;
          fstop      = 1'b1;
        end
        cycle_open_d = 1'b0;
      end
      default: ;
    endcase
  end

  // State commits as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beep_q   <= '0;
      full_run_q    <= 1'b0;
      any_alarm_q   <= 1'b0;
      cycle_open_q  <= 1'b0;
      zone_flags_q  <= '0;
      phase_q       <= 1'b0;
      phase_timer_q <= '0;
      remote_q      <= 1'b0;
    end else if (s1_adv) begin
      last_beep_q   <= last_beep_d;
      full_run_q    <= full_run_d;
      any_alarm_q   <= any_alarm_d;
      cycle_open_q  <= cycle_open_d;
      zone_flags_q  <= zone_flags_d;
      phase_q       <= phase_d;
      phase_timer_q <= phase_timer_d;
      remote_q      <= remote_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic                          res_hit_q;
  logic                          res_beep_q;
  logic                          res_start_q;
  logic                          res_stop_q;
  logic [tam_pkg::ZoneMaskW-1:0] res_mask_q;
  logic                          res_remote_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_hit_q    <= hit;
      res_beep_q   <= beep;
      res_start_q  <= fstart;
      res_stop_q   <= fstop;
      res_mask_q   <= phase_d ? zone_flags_d : '0;
      res_remote_q <= remote_d & phase_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign alarm_hit_o        = res_hit_q;
  assign beep_request_o     = res_beep_q;
  assign full_flash_start_o = res_start_q;
  assign full_flash_stop_o  = res_stop_q;
  assign zone_flash_mask_o  = res_mask_q;
  assign remote_alarm_on_o  = res_remote_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a beep or a flash start only comes from a slot check that hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (beep_request_o || full_flash_start_o) |-> alarm_hit_o)
    else $error("beep or flash start without alarm hit");

  // a cycle end never reports a hit, so start and stop are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_flash_start_o && full_flash_stop_o))
    else $error("flash start and stop in one result");

  // input side only stalls while both registers hold items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // a start pulse leaves the full flash running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && fstart |=> full_run_q)
    else $error("full flash not running after start");

  // mask only shows while the flash phase is on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s1_adv) && !phase_q |-> res_mask_q == '0 && !res_remote_q)
    else $error("flash outputs set during off phase");

endmodule
